// ===== design/dgr_pkg.sv =====
package dgr_pkg;

  localparam int MAP_SIZE    = 32;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAP_CELLS   = MAP_SIZE * MAP_SIZE;
  localparam int MAP_AW      = $clog2(MAP_CELLS);
  localparam int COORD_W     = $clog2(MAP_SIZE) + 2;

  localparam int DIST_W = 24;
  localparam int RAY_W  = 43;
  localparam int CAM_W  = 27;
  localparam int DVD_W  = 25;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA_X     = 3'd0,
    REG_CAMERA_Y     = 3'd1,
    REG_FACING_X     = 3'd2,
    REG_FACING_Y     = 3'd3,
    REG_LENS_X       = 3'd4,
    REG_LENS_Y       = 3'd5,
    REG_SCREEN_WIDTH = 3'd6,
    REG_DRAW_LIMIT   = 3'd7
  } reg_idx_e;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [9:0]        column;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic              cell_is_wall;
  } in_item_t;

  typedef struct packed {
    logic [9:0]        out_column;
    logic              wall_hit;
    logic              hit_side;
    logic [DIST_W-1:0] wall_distance;
  } out_item_t;

  typedef struct packed {
    logic [20:0]        camera_x;
    logic [20:0]        camera_y;
    logic signed [15:0] facing_x;
    logic signed [15:0] facing_y;
    logic signed [15:0] lens_x;
    logic signed [15:0] lens_y;
    logic [10:0]        screen_width;
    logic [DIST_W-1:0]  draw_limit;
  } cfg_t;

  typedef struct packed {
    logic              is_cast;
    logic [9:0]        column;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic              cell_is_wall;
    logic [DIST_W-1:0] delta_x;
    logic [DIST_W-1:0] delta_y;
    logic [DIST_W-1:0] side_x;
    logic [DIST_W-1:0] side_y;
    logic              neg_x;
    logic              neg_y;
  } job_t;

endpackage

// ===== design/dgr_ram.sv =====
module dgr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/dgr_fifo.sv =====
module dgr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dgr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dgr_pkg::job_t data_o
);

  dgr_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== design/dgr_front.sv =====
module dgr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dgr_pkg::cfg_t     cfg_i,
  input  logic              push_i,
  input  dgr_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              job_push_o,
  output dgr_pkg::job_t     job_o,
  input  logic              job_full_i
);

  typedef enum logic [2:0] {S_IDLE, S_CDIV, S_MUL, S_DDIV, S_SIDE, S_PUSH} state_e;

  state_e state_q;
  dgr_pkg::job_t job_q;
  logic [dgr_pkg::RAY_W-1:0]  rem_q, dvs_q;
  logic [dgr_pkg::DVD_W-1:0]  dvd_q, quo_q;
  logic [dgr_pkg::CNT_W-1:0]  cnt_q;
  logic signed [dgr_pkg::CAM_W-1:0] cam_q;
  logic axis_q, neg_q;
  logic [dgr_pkg::DIST_W-1:0] d_q;

  logic [dgr_pkg::RAY_W-1:0]  wdiv, rem_sh, rem_d, mag;
  logic [dgr_pkg::DVD_W-1:0]  quo_d;
  logic ge;
  logic signed [dgr_pkg::RAY_W-1:0] fac_e, lens_e, cam_e, ray;
  logic [20:0] pos;
  logic [16:0] frac;
  logic [40:0] sprod;
  logic [dgr_pkg::DIST_W-1:0] side;

  assign full_o     = (state_q != S_IDLE);
  assign job_push_o = (state_q == S_PUSH);
  assign job_o      = job_q;

  always_comb begin
    if (cfg_i.screen_width == '0) begin
      wdiv = dgr_pkg::RAY_W'(1);
    end else if (32'(cfg_i.screen_width) > dgr_pkg::MAX_COLUMNS) begin
      wdiv = dgr_pkg::RAY_W'(dgr_pkg::MAX_COLUMNS);
    end else begin
      wdiv = dgr_pkg::RAY_W'(cfg_i.screen_width);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[dgr_pkg::RAY_W-2:0], dvd_q[dgr_pkg::DVD_W-1]};
  assign ge     = (rem_sh >= dvs_q);
  assign rem_d  = ge ? rem_sh - dvs_q : rem_sh;
  assign quo_d  = {quo_q[dgr_pkg::DVD_W-2:0], ge};

  assign fac_e  = dgr_pkg::RAY_W'(axis_q ? cfg_i.facing_y : cfg_i.facing_x);
  assign lens_e = dgr_pkg::RAY_W'(axis_q ? cfg_i.lens_y : cfg_i.lens_x);
  assign cam_e  = dgr_pkg::RAY_W'(cam_q);
  assign ray    = (fac_e <<< 14) + lens_e * cam_e;
  assign mag    = ray[dgr_pkg::RAY_W-1] ? dgr_pkg::RAY_W'(-ray) : dgr_pkg::RAY_W'(ray);

  assign pos   = axis_q ? cfg_i.camera_y : cfg_i.camera_x;
  assign frac  = neg_q ? {1'b0, pos[15:0]} : 17'h10000 - {1'b0, pos[15:0]};
  assign sprod = 41'(frac) * 41'(d_q);
  assign side  = (sprod[40:40] != 1'b0) ? dgr_pkg::DIST_MAX : sprod[39:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (push_i) begin
            job_q.is_cast      <= item_i.command;
            job_q.column       <= item_i.column;
            job_q.cell_x       <= item_i.cell_x;
            job_q.cell_y       <= item_i.cell_y;
            job_q.cell_is_wall <= item_i.cell_is_wall;
            rem_q  <= '0;
            dvd_q  <= {item_i.column, 15'b0};
            dvs_q  <= wdiv;
            quo_q  <= '0;
            cnt_q  <= dgr_pkg::CNT_W'(dgr_pkg::DVD_W);
            axis_q <= 1'b0;
            state_q <= (item_i.command == dgr_pkg::CMD_CAST) ? S_CDIV : S_PUSH;
          end
        end
        S_CDIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          dvd_q <= dvd_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == dgr_pkg::CNT_W'(1)) begin
            cam_q   <= $signed({2'b00, quo_d}) - dgr_pkg::CAM_W'(16384);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          neg_q <= ray[dgr_pkg::RAY_W-1];
          if (mag <= dgr_pkg::RAY_W'(1 << 20)) begin
            // short ray component: delta saturates, skip the divide
            d_q     <= dgr_pkg::DIST_MAX;
            state_q <= S_SIDE;
          end else begin
            rem_q   <= dgr_pkg::RAY_W'(1 << 20);
            dvd_q   <= '0;
            dvs_q   <= mag;
            quo_q   <= '0;
            cnt_q   <= dgr_pkg::CNT_W'(dgr_pkg::DIST_W);
            state_q <= S_DDIV;
          end
        end
        S_DDIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == dgr_pkg::CNT_W'(1)) begin
            d_q     <= quo_d[dgr_pkg::DIST_W-1:0];
            state_q <= S_SIDE;
          end
        end
        S_SIDE: begin
          if (!axis_q) begin
            job_q.delta_x <= d_q;
            job_q.side_x  <= side;
            job_q.neg_x   <= neg_q;
            axis_q  <= 1'b1;
            state_q <= S_MUL;
          end else begin
            job_q.delta_y <= d_q;
            job_q.side_y  <= side;
            job_q.neg_y   <= neg_q;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!job_full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/dgr_back.sv =====
module dgr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dgr_pkg::cfg_t      cfg_i,
  input  logic               job_empty_i,
  input  dgr_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output dgr_pkg::out_item_t item_o
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WALK, S_CHECK, S_RESULT} state_e;

  state_e state_q;
  logic [dgr_pkg::MAP_AW-1:0] clr_q;
  logic [dgr_pkg::DIST_W-1:0] sdx_q, sdy_q, dx_q, dy_q, dist_q;
  logic signed [dgr_pkg::COORD_W-1:0] mx_q, my_q;
  logic neg_x_q, neg_y_q, side_q, hit_q;
  logic [9:0] col_q;
  logic out_valid_q;
  dgr_pkg::out_item_t out_q;

  logic ram_we, ram_rdata, ram_wdata;
  logic [dgr_pkg::MAP_AW-1:0] ram_waddr, ram_raddr;
  logic take_x;
  logic signed [dgr_pkg::COORD_W-1:0] mx_n, my_n;
  logic off_map;
  logic [dgr_pkg::DIST_W:0] sum_x, sum_y;

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;
  assign job_pop_o = (state_q == S_IDLE) && !job_empty_i;

  // map write: clearing sweep after reset, then write items that land on the map
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 1'b0;
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (job_pop_o && !job_i.is_cast) begin
      ram_we    = (32'(job_i.cell_x) < dgr_pkg::MAP_SIZE) &&
                  (32'(job_i.cell_y) < dgr_pkg::MAP_SIZE);
      ram_waddr = dgr_pkg::MAP_AW'(job_i.cell_y) * dgr_pkg::MAP_AW'(dgr_pkg::MAP_SIZE)
                + dgr_pkg::MAP_AW'(job_i.cell_x);
      ram_wdata = job_i.cell_is_wall;
    end
  end

  // one DDA step: x on strictly smaller side distance, y otherwise
  assign take_x = (sdx_q < sdy_q);
  assign mx_n = take_x ? (neg_x_q ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign my_n = take_x ? my_q : (neg_y_q ? my_q - 1'b1 : my_q + 1'b1);
  assign off_map = mx_n[dgr_pkg::COORD_W-1] || my_n[dgr_pkg::COORD_W-1] ||
                   (mx_n >= dgr_pkg::COORD_W'(dgr_pkg::MAP_SIZE)) ||
                   (my_n >= dgr_pkg::COORD_W'(dgr_pkg::MAP_SIZE));
  assign ram_raddr = dgr_pkg::MAP_AW'(my_n) * dgr_pkg::MAP_AW'(dgr_pkg::MAP_SIZE)
                   + dgr_pkg::MAP_AW'(mx_n);
  assign sum_x = {1'b0, sdx_q} + {1'b0, dx_q};
  assign sum_y = {1'b0, sdy_q} + {1'b0, dy_q};

  dgr_ram #(
    .WIDTH(1),
    .DEPTH(dgr_pkg::MAP_CELLS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (pop_i && out_valid_q && (state_q != S_RESULT)) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == dgr_pkg::MAP_AW'(dgr_pkg::MAP_CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!job_empty_i && job_i.is_cast) begin
            sdx_q   <= job_i.side_x;
            sdy_q   <= job_i.side_y;
            dx_q    <= job_i.delta_x;
            dy_q    <= job_i.delta_y;
            neg_x_q <= job_i.neg_x;
            neg_y_q <= job_i.neg_y;
            col_q   <= job_i.column;
            mx_q    <= dgr_pkg::COORD_W'(cfg_i.camera_x[20:16]);
            my_q    <= dgr_pkg::COORD_W'(cfg_i.camera_y[20:16]);
            dist_q  <= '0;
            side_q  <= 1'b0;
            hit_q   <= 1'b0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (dist_q >= cfg_i.draw_limit) begin
            state_q <= S_RESULT;
          end else begin
            mx_q <= mx_n;
            my_q <= my_n;
            if (take_x) begin
              dist_q <= sdx_q;
              sdx_q  <= sum_x[dgr_pkg::DIST_W] ? dgr_pkg::DIST_MAX : sum_x[dgr_pkg::DIST_W-1:0];
              side_q <= 1'b0;
            end else begin
              dist_q <= sdy_q;
              sdy_q  <= sum_y[dgr_pkg::DIST_W] ? dgr_pkg::DIST_MAX : sum_y[dgr_pkg::DIST_W-1:0];
              side_q <= 1'b1;
            end
            if (off_map) begin
              hit_q   <= 1'b1;
              state_q <= S_RESULT;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (ram_rdata) begin
            hit_q   <= 1'b1;
            state_q <= S_RESULT;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || pop_i) begin
            out_q.out_column    <= col_q;
            out_q.wall_hit      <= hit_q;
            out_q.hit_side      <= hit_q & side_q;
            out_q.wall_distance <= hit_q ? dist_q : '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/dda_grid_raycaster.sv =====
// Setup: a cast divides for the column offset, then per axis runs a multiply,
//   a divide (skipped when the delta saturates) and a scale step; each walk step
//   passes a step state and a map-check state; map writes land when dequeued.
// Throughput: one item at a time in the front; setup of the next cast overlaps
//   the walk of the previous one through a two-entry queue.
// Reset: asynchronous, active low; a sweep then clears every map cell.
module dda_grid_raycaster (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  dgr_pkg::in_item_t                in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output dgr_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [dgr_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [dgr_pkg::CFG_W-1:0]        cfg_data_i
);

  dgr_pkg::cfg_t cfg_q;
  dgr_pkg::job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x     <= 21'd1048576;
      cfg_q.camera_y     <= 21'd1048576;
      cfg_q.facing_x     <= -16'sd16384;
      cfg_q.facing_y     <= 16'sd0;
      cfg_q.lens_x       <= 16'sd0;
      cfg_q.lens_y       <= 16'sd10813;
      cfg_q.screen_width <= 11'd320;
      cfg_q.draw_limit   <= 24'd1048576;
    end else if (cfg_we_i) begin
      case (dgr_pkg::reg_idx_e'(cfg_idx_i))
        dgr_pkg::REG_CAMERA_X:     cfg_q.camera_x     <= cfg_data_i[20:0];
        dgr_pkg::REG_CAMERA_Y:     cfg_q.camera_y     <= cfg_data_i[20:0];
        dgr_pkg::REG_FACING_X:     cfg_q.facing_x     <= cfg_data_i[15:0];
        dgr_pkg::REG_FACING_Y:     cfg_q.facing_y     <= cfg_data_i[15:0];
        dgr_pkg::REG_LENS_X:       cfg_q.lens_x       <= cfg_data_i[15:0];
        dgr_pkg::REG_LENS_Y:       cfg_q.lens_y       <= cfg_data_i[15:0];
        dgr_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i[10:0];
        dgr_pkg::REG_DRAW_LIMIT:   cfg_q.draw_limit   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // front: accept, classify, set up ray deltas and side distances
  dgr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .item_i    (in_item_i),
    .full_o    (full),
    .job_push_o(job_push),
    .job_o     (job_in),
    .job_full_i(job_full)
  );

  // hold up to two prepared transfers between setup and walk
  dgr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (job_out)
  );

  // back: map writes and the grid walk, one map read per step
  dgr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .item_o     (out_item_o)
  );

endmodule
